// ===== design/swashplateless_rotor_mixer_core_macros.svh =====
// Assertion macros for the rotor mixer RTL
`ifndef SWASHPLATELESS_ROTOR_MIXER_CORE_MACROS_SVH
`define SWASHPLATELESS_ROTOR_MIXER_CORE_MACROS_SVH

// same-cycle implication
`define SRM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("srm: assertion failed");

// next-cycle implication
`define SRM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("srm: assertion failed");

`endif

// ===== design/srm_pkg.sv =====
// Types and constants of the rotor mixer
package srm_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned GAIN_FRAC = 8;

  localparam logic [14:0] OUT_MAX = 15'h7FFF;

  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21024;
  localparam logic [15:0] SIN_C = 16'd2320;
  localparam logic [15:0] QUARTER = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPIN_DIRECTION = 3'd0,
    CFG_CYCLIC_GAIN    = 3'd1,
    CFG_PHASE_OFFSET   = 3'd2,
    CFG_FORCE_GAIN     = 3'd3,
    CFG_TORQUE_GAIN    = 3'd4,
    CFG_PROP_DISTANCE  = 3'd5
  } srm_cfg_e;

endpackage

// ===== design/srm_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage
module srm_div_pipe #(
  parameter int unsigned DW = 35
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [DW-1:0]                  dividend_i,
  input  logic [srm_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic [DW-1:0]                  quotient_o
);
  import srm_pkg::*;

  logic [DIVISOR_W-1:0] rem_q [DW-1];
  logic [DW-1:0]        low_q [DW];
  logic [DIVISOR_W-1:0] dvs_q [DW-1];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DIVISOR_W-1:0] rem_in;
    logic [DIVISOR_W-1:0] dvs_in;
    logic [DW-1:0]        low_in;
    logic [DIVISOR_W:0]   r;
    logic [DIVISOR_W:0]   rn;
    logic                 ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign low_in = dividend_i;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end

    assign r  = {rem_in, low_in[DW-1]};
    assign ge = (r >= {1'b0, dvs_in});
    assign rn = ge ? (r - {1'b0, dvs_in}) : r;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[k] <= {low_in[DW-2:0], ge};
      end
    end

    if (k < DW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rn[DIVISOR_W-1:0];
          dvs_q[k] <= dvs_in;
        end
      end
    end
  end

  assign quotient_o = low_q[DW-1];

endmodule

// ===== design/swashplateless_rotor_mixer_core.sv =====
// Swashplateless rotor mixer: one motor command per rotor angle sample
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_ready_o    | rotor_angle_i, thrust_*, torque_*
//  out     | source    | out_valid_o / out_ready_i  | motor_command_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One transaction per cycle, except that the whole pipeline holds while the output
// register is full and not taken. The four bit-per-stage dividers (FRAC_BITS + 23
// stages) make up most of the pipeline length.
// Reset clears valid bits and loads register defaults; no clearing pass.
module swashplateless_rotor_mixer_core #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [15:0]                      rotor_angle_i,
  input  logic signed [15:0]               thrust_x_i,
  input  logic signed [15:0]               thrust_y_i,
  input  logic signed [15:0]               thrust_z_i,
  input  logic signed [15:0]               torque_x_i,
  input  logic signed [15:0]               torque_y_i,
  input  logic signed [15:0]               torque_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [14:0]                      motor_command_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [srm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [srm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import srm_pkg::*;

  localparam int unsigned DW = 23 + FRAC_BITS;
  localparam int unsigned FS = FRAC_BITS - GAIN_FRAC;
  localparam int unsigned NW = DW + 2;
  localparam int unsigned PW = NW + 18;
  localparam int unsigned DF = PW + 1;
  localparam int unsigned RW = DF - 15;
  localparam int unsigned MW = RW + 16;
  localparam int unsigned CW = MW - 7;
  localparam int unsigned PIPE_LEN = DW + 9;
  localparam logic [15:0] TZ_FLOOR = 16'(((5 << FRAC_BITS) + 50) / 100);

  typedef struct packed {
    logic [3:0]         sgn;
    logic [1:0]         quad;
    logic [14:0]        frac;
    logic signed [15:0] tz;
    logic signed [15:0] qz;
  } side_t;

  function automatic logic [30:0] mag31(input logic signed [31:0] v);
    logic [31:0] a;
    a = v[31] ? 32'(-v) : 32'(v);
    return a[30:0];
  endfunction

  // configuration
  logic [1:0]         spin_q;
  logic signed [15:0] cgain_q, fgain_q, tgain_q;
  logic [15:0]        offset_q, pdist_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_q   <= 2'b01;
      cgain_q  <= 16'sd256;
      offset_q <= 16'd0;
      fgain_q  <= 16'sd256;
      tgain_q  <= 16'sd256;
      pdist_q  <= 16'd256;
    end else if (cfg_valid_i) begin
      unique case (srm_cfg_e'(cfg_index_i))
        CFG_SPIN_DIRECTION: spin_q   <= cfg_data_i[1:0];
        CFG_CYCLIC_GAIN:    cgain_q  <= cfg_data_i;
        CFG_PHASE_OFFSET:   offset_q <= cfg_data_i;
        CFG_FORCE_GAIN:     fgain_q  <= cfg_data_i;
        CFG_TORQUE_GAIN:    tgain_q  <= cfg_data_i;
        CFG_PROP_DISTANCE:  pdist_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic dir_neg;
  logic [15:0] pd_eff;
  assign dir_neg = spin_q[1];
  assign pd_eff  = (pdist_q == 16'd0) ? 16'd1 : pdist_q;

  // valid chain, global stall
  logic                pipe_en;
  logic [PIPE_LEN-1:0] vld_q, vld_d;

  assign pipe_en     = !vld_q[PIPE_LEN-1] || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign out_valid_o = vld_q[PIPE_LEN-1];
  assign vld_d       = {vld_q[PIPE_LEN-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= vld_d;
    end
  end

  // stage A: gain products, tz floor, angle
  logic signed [31:0] a_pqx_q, a_pqy_q, a_ptx_q, a_pty_q;
  logic [15:0]        a_tzf_q;
  logic [1:0]         a_quad_q;
  logic [14:0]        a_frac_q;
  logic signed [15:0] a_tz_q, a_qz_q;
  logic [31:0]        ang_diff;
  logic [ANGLE_BITS-1:0] ang_b;
  logic [31:0]        ang_p;

  assign ang_diff = {16'd0, rotor_angle_i} - {16'd0, offset_q};
  assign ang_b    = ang_diff[ANGLE_BITS-1:0];
  assign ang_p    = 32'(ang_b) << (32 - ANGLE_BITS);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_pqx_q  <= torque_x_i * tgain_q;
      a_pqy_q  <= torque_y_i * tgain_q;
      a_ptx_q  <= thrust_x_i * fgain_q;
      a_pty_q  <= thrust_y_i * fgain_q;
      a_tzf_q  <= ($signed({thrust_z_i[15], thrust_z_i}) > $signed({1'b0, TZ_FLOOR}))
                  ? thrust_z_i : TZ_FLOOR;
      a_quad_q <= ang_p[31:30];
      a_frac_q <= ang_p[29:15];
      a_tz_q   <= thrust_z_i;
      a_qz_q   <= torque_z_i;
    end
  end

  // dividers: sgn[0] nx torque, sgn[1] nx thrust, sgn[2] ny torque, sgn[3] ny thrust
  logic [DW-1:0] quo_nx1, quo_nx2, quo_ny1, quo_ny2;

  srm_div_pipe #(.DW(DW)) u_div_nx1 (
    .clk_i, .en_i(pipe_en), .dividend_i(DW'(mag31(a_pqy_q))), .divisor_i(pd_eff),
    .quotient_o(quo_nx1)
  );
  srm_div_pipe #(.DW(DW)) u_div_nx2 (
    .clk_i, .en_i(pipe_en), .dividend_i(DW'(mag31(a_ptx_q)) << FS), .divisor_i(a_tzf_q),
    .quotient_o(quo_nx2)
  );
  srm_div_pipe #(.DW(DW)) u_div_ny1 (
    .clk_i, .en_i(pipe_en), .dividend_i(DW'(mag31(a_pqx_q))), .divisor_i(pd_eff),
    .quotient_o(quo_ny1)
  );
  srm_div_pipe #(.DW(DW)) u_div_ny2 (
    .clk_i, .en_i(pipe_en), .dividend_i(DW'(mag31(a_pty_q)) << FS), .divisor_i(a_tzf_q),
    .quotient_o(quo_ny2)
  );

  side_t side_in;
  side_t side_q [DW];

  assign side_in = '{sgn:  {a_pty_q[31], a_pqx_q[31], a_ptx_q[31], !a_pqy_q[31]},
                     quad: a_quad_q, frac: a_frac_q, tz: a_tz_q, qz: a_qz_q};

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < DW; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // P1: tilt vector, x^2
  side_t              s_o;
  logic signed [NW-1:0] q_nx1, q_nx2, q_ny1, q_ny2;
  logic [15:0]        xa_c, xb_c;
  logic [31:0]        sqa, sqb;

  assign s_o   = side_q[DW-1];
  assign q_nx1 = $signed({2'b00, quo_nx1});
  assign q_nx2 = $signed({2'b00, quo_nx2});
  assign q_ny1 = $signed({2'b00, quo_ny1});
  assign q_ny2 = $signed({2'b00, quo_ny2});
  assign xa_c  = {1'b0, s_o.frac};
  assign xb_c  = QUARTER - {1'b0, s_o.frac};
  assign sqa   = xa_c * xa_c;
  assign sqb   = xb_c * xb_c;

  logic signed [NW-1:0] p1_nx_q, p1_ny_q, p2_nx_q, p2_ny_q, p3_nx_q, p3_ny_q;
  logic signed [NW-1:0] p4_nx_q, p4_ny_q;
  logic [15:0] p1_xa_q, p1_xb_q, p1_x2a_q, p1_x2b_q;
  logic [15:0] p2_xa_q, p2_xb_q, p2_x2a_q, p2_x2b_q, p2_t1a_q, p2_t1b_q;
  logic [15:0] p3_xa_q, p3_xb_q, p3_t2a_q, p3_t2b_q;
  logic [16:0] p4_sa_q, p4_sb_q;
  logic [1:0]  p1_quad_q, p2_quad_q, p3_quad_q, p4_quad_q;
  logic signed [15:0] p1_tz_q, p2_tz_q, p3_tz_q, p4_tz_q, p5_tz_q, p6_tz_q, p7_tz_q;
  logic signed [15:0] p1_qz_q, p2_qz_q, p3_qz_q, p4_qz_q, p5_qz_q, p6_qz_q, p7_qz_q;

  logic [27:0] m1a, m1b;
  logic [31:0] m2a, m2b, m3a, m3b;

  assign m1a = p1_x2a_q * SIN_C[11:0];
  assign m1b = p1_x2b_q * SIN_C[11:0];
  assign m2a = p2_x2a_q * (SIN_B - p2_t1a_q);
  assign m2b = p2_x2b_q * (SIN_B - p2_t1b_q);
  assign m3a = p3_xa_q * (SIN_A - p3_t2a_q);
  assign m3b = p3_xb_q * (SIN_A - p3_t2b_q);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p1_nx_q   <= (s_o.sgn[0] ? -q_nx1 : q_nx1) + (s_o.sgn[1] ? -q_nx2 : q_nx2);
      p1_ny_q   <= (s_o.sgn[2] ? -q_ny1 : q_ny1) + (s_o.sgn[3] ? -q_ny2 : q_ny2);
      p1_xa_q   <= xa_c;
      p1_xb_q   <= xb_c;
      p1_x2a_q  <= sqa[30:15];
      p1_x2b_q  <= sqb[30:15];
      p1_quad_q <= s_o.quad;
      p1_tz_q   <= s_o.tz;
      p1_qz_q   <= s_o.qz;

      p2_nx_q   <= p1_nx_q;
      p2_ny_q   <= p1_ny_q;
      p2_xa_q   <= p1_xa_q;
      p2_xb_q   <= p1_xb_q;
      p2_x2a_q  <= p1_x2a_q;
      p2_x2b_q  <= p1_x2b_q;
      p2_t1a_q  <= 16'(m1a >> 15);
      p2_t1b_q  <= 16'(m1b >> 15);
      p2_quad_q <= p1_quad_q;
      p2_tz_q   <= p1_tz_q;
      p2_qz_q   <= p1_qz_q;

      p3_nx_q   <= p2_nx_q;
      p3_ny_q   <= p2_ny_q;
      p3_xa_q   <= p2_xa_q;
      p3_xb_q   <= p2_xb_q;
      p3_t2a_q  <= 16'(m2a >> 15);
      p3_t2b_q  <= 16'(m2b >> 15);
      p3_quad_q <= p2_quad_q;
      p3_tz_q   <= p2_tz_q;
      p3_qz_q   <= p2_qz_q;

      p4_nx_q   <= p3_nx_q;
      p4_ny_q   <= p3_ny_q;
      p4_sa_q   <= 17'(m3a >> 15);
      p4_sb_q   <= 17'(m3b >> 15);
      p4_quad_q <= p3_quad_q;
      p4_tz_q   <= p3_tz_q;
      p4_qz_q   <= p3_qz_q;
    end
  end

  // P5: sin/cos and products
  logic [16:0]        sin_mag, cos_mag;
  logic signed [17:0] sin_v, cos_v;
  logic signed [PW-1:0] p5_ys_q, p5_xc_q;
  logic signed [DF-1:0] diff_c;
  logic signed [RW-1:0] p6_rot_q;
  logic signed [MW-1:0] p7_mul_q;
  logic signed [CW-1:0] cmd_c, zq_c;
  logic [14:0]        cmd_q;

  assign sin_mag = p4_quad_q[0] ? p4_sb_q : p4_sa_q;
  assign cos_mag = p4_quad_q[0] ? p4_sa_q : p4_sb_q;
  assign sin_v   = p4_quad_q[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_v   = (p4_quad_q[1] ^ p4_quad_q[0]) ? -$signed({1'b0, cos_mag})
                                                  : $signed({1'b0, cos_mag});

  assign diff_c = dir_neg ? (DF'(p5_ys_q) + DF'(p5_xc_q)) : (DF'(p5_ys_q) - DF'(p5_xc_q));
  assign zq_c   = dir_neg ? CW'(p7_qz_q) : -CW'(p7_qz_q);
  assign cmd_c  = CW'(p7_mul_q >>> GAIN_FRAC) + CW'(p7_tz_q) + zq_c;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p5_ys_q  <= p4_ny_q * sin_v;
      p5_xc_q  <= p4_nx_q * cos_v;
      p5_tz_q  <= p4_tz_q;
      p5_qz_q  <= p4_qz_q;

      p6_rot_q <= RW'(diff_c >>> 15);
      p6_tz_q  <= p5_tz_q;
      p6_qz_q  <= p5_qz_q;

      p7_mul_q <= p6_rot_q * cgain_q;
      p7_tz_q  <= p6_tz_q;
      p7_qz_q  <= p6_qz_q;

      if (cmd_c < 0) begin
        cmd_q <= '0;
      end else if (cmd_c > $signed(CW'(OUT_MAX))) begin
        cmd_q <= OUT_MAX;
      end else begin
        cmd_q <= cmd_c[14:0];
      end
    end
  end

  assign motor_command_o = cmd_q;

  `include "swashplateless_rotor_mixer_core_macros.svh"

  `SRM_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, !pipe_en, vld_q == $past(vld_q))
  `SRM_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, in_valid_i && in_ready_o, vld_q[0])
  `SRM_ASSERT_NXT(a_drain, clk_i, rst_ni, pipe_en && !vld_q[PIPE_LEN-2], !out_valid_o)

endmodule

// ===== tb/swashplateless_rotor_mixer_core_test.sv =====
// Self-checking testbench for the swashplateless rotor mixer core
`timescale 1ns / 100ps

module swashplateless_rotor_mixer_core_test;
  import srm_pkg::*;

  localparam int unsigned LATENCY = 44;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 550;

  typedef struct packed {
    logic [15:0] angle;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } sample_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [15:0] rotor_angle_i;
  logic signed [15:0] thrust_x_i, thrust_y_i, thrust_z_i;
  logic signed [15:0] torque_x_i, torque_y_i, torque_z_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [14:0] motor_command_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // mirrored register file
  logic [1:0] spin_dir;
  logic [15:0] cyc_gain, ph_offset, f_gain, t_gain, p_dist;

  sample_t pending_samples[$];
  logic [14:0] expected_commands[$];
  int unsigned mismatches;
  int unsigned watchdog;
  int unsigned burst_left, gap_left;
  int unsigned hold_cycles;
  bit pause_stall;
  bit sender_enable;
  bit stall_mode;

  swashplateless_rotor_mixer_core i_dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) + ((longint'(1) << s) - 1)) >>> s);
  endfunction

  function automatic longint quarter_wave(longint x);
    longint x2, t;
    x2 = (x * x) >>> 15;
    t = (x2 * 2320) >>> 15;
    t = 21024 - t;
    t = (x2 * t) >>> 15;
    t = 51472 - t;
    return (x * t) >>> 15;
  endfunction

  function automatic longint wave_q15(logic [31:0] p);
    longint x, v;
    x = longint'(p[29:15]);
    v = p[30] ? quarter_wave(32768 - x) : quarter_wave(x);
    return p[31] ? -v : v;
  endfunction

  function automatic logic [14:0] mix_command(sample_t s);
    longint dir, tzf, pd, nx, ny, rot, cmd;
    logic [15:0] b;
    logic [31:0] p;
    dir = spin_dir[1] ? -1 : 1;
    pd = (p_dist == 0) ? 1 : longint'(p_dist);
    tzf = (longint'(s.fz) > 205) ? longint'(s.fz) : 205;
    nx = (-longint'(s.qy) * longint'($signed(t_gain))) / pd
       + (longint'(s.fx) * longint'($signed(f_gain)) * 16) / tzf;
    ny = (longint'(s.qx) * longint'($signed(t_gain))) / pd
       + (longint'(s.fy) * longint'($signed(f_gain)) * 16) / tzf;
    b = s.angle - ph_offset;
    p = {b, 16'h0000};
    rot = ny * wave_q15(p) - dir * nx * wave_q15(p + 32'h4000_0000);
    rot = floor_shr(rot, 15);
    cmd = floor_shr(longint'($signed(cyc_gain)) * rot, 8) + longint'(s.fz)
        - dir * longint'(s.qz);
    if (cmd < 0) cmd = 0;
    if (cmd > 32767) cmd = 32767;
    return cmd[14:0];
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) expected_commands.push_back(mix_command({rotor_angle_i,
          thrust_x_i, thrust_y_i, thrust_z_i, torque_x_i, torque_y_i, torque_z_i}));
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (sender_enable && pending_samples.size() != 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        {rotor_angle_i, thrust_x_i, thrust_y_i, thrust_z_i,
         torque_x_i, torque_y_i, torque_z_i} <= s;
        in_valid_i <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      mismatches <= 0;
      watchdog <= 0;
      hold_cycles <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_commands.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected command %0d", motor_command_o);
        end else begin
          logic [14:0] want;
          want = expected_commands.pop_front();
          if (want !== motor_command_o) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("command mismatch: expected %0d actual %0d", want, motor_command_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o))
        watchdog <= 0;
      else
        watchdog <= watchdog + 1;
      if (pause_stall && hold_cycles == 0) hold_cycles <= 300;
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready_i <= 1'b0;
      end else if (stall_mode) begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("swashplateless_rotor_mixer_core verification failed");
      $finish;
    end
  end

  function automatic sample_t random_sample();
    sample_t s;
    s = 112'({$urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 3))
      0: begin
        s.fx = 16'(int'($urandom_range(0, 4000)) - 2000);
        s.fy = 16'(int'($urandom_range(0, 4000)) - 2000);
        s.fz = 16'($urandom_range(0, 8192));
        s.qx = 16'(int'($urandom_range(0, 2000)) - 1000);
        s.qy = 16'(int'($urandom_range(0, 2000)) - 1000);
        s.qz = 16'(int'($urandom_range(0, 1000)) - 500);
      end
      1: s.fz = 16'($urandom_range(0, 300));
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_reg(srm_cfg_e idx, logic [15:0] value);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SPIN_DIRECTION: spin_dir = value[1:0];
      CFG_CYCLIC_GAIN: cyc_gain = value;
      CFG_PHASE_OFFSET: ph_offset = value;
      CFG_FORCE_GAIN: f_gain = value;
      CFG_TORQUE_GAIN: t_gain = value;
      default: p_dist = value;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_commands.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) pending_samples.push_back(random_sample());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SPIN_DIRECTION;
    cfg_data_i = '0;
    {rotor_angle_i, thrust_x_i, thrust_y_i, thrust_z_i,
     torque_x_i, torque_y_i, torque_z_i} = '0;
    sender_enable = 1'b1;
    stall_mode = 1'b0;
    pause_stall = 1'b0;
    spin_dir = 2'd1;
    cyc_gain = 16'd256;
    ph_offset = 16'd0;
    f_gain = 16'd256;
    t_gain = 16'd256;
    p_dist = 16'd256;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, zero tilt, thrust floor, clamp and saturation
    pending_samples.push_back('0);
    pending_samples.push_back({16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    pending_samples.push_back({16'h4000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    pending_samples.push_back({16'h8000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h0000});
    pending_samples.push_back({16'hC000, 16'h0400, 16'h0400, 16'h0001, 16'h0000, 16'h0000, 16'h0000});
    pending_samples.push_back({16'h2000, 16'h0400, 16'hFC00, 16'd205, 16'h0100, 16'hFF00, 16'h0200});
    pending_samples.push_back({16'h1234, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000});
    pending_samples.push_back({16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF});
    drain();

    write_reg(CFG_SPIN_DIRECTION, 16'h0003);
    write_reg(CFG_PHASE_OFFSET, 16'hFFFF);
    write_reg(CFG_PROP_DISTANCE, 16'h0000);
    pending_samples.push_back({16'h0000, 16'h0100, 16'h0100, 16'h1000, 16'h0100, 16'h0100, 16'h0100});
    pending_samples.push_back({16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000});
    drain();
    write_reg(CFG_SPIN_DIRECTION, 16'h0000);
    write_reg(CFG_CYCLIC_GAIN, 16'h7FFF);
    write_reg(CFG_FORCE_GAIN, 16'h8000);
    write_reg(CFG_TORQUE_GAIN, 16'h7FFF);
    write_reg(CFG_PROP_DISTANCE, 16'h0001);
    stall_mode = 1'b1;
    run_random(50);

    // long output hold while the sender keeps offering
    write_reg(CFG_SPIN_DIRECTION, 16'h0002);
    write_reg(CFG_CYCLIC_GAIN, 16'h8000);
    write_reg(CFG_PHASE_OFFSET, 16'h8000);
    write_reg(CFG_FORCE_GAIN, 16'h7FFF);
    write_reg(CFG_TORQUE_GAIN, 16'h8000);
    write_reg(CFG_PROP_DISTANCE, 16'hFFFF);
    repeat (50) pending_samples.push_back(random_sample());
    pause_stall = 1'b1;
    wait (hold_cycles != 0);
    pause_stall = 1'b0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(CFG_SPIN_DIRECTION, 16'($urandom_range(0, 3)));
      write_reg(CFG_CYCLIC_GAIN, 16'($urandom));
      write_reg(CFG_PHASE_OFFSET, 16'($urandom));
      write_reg(CFG_FORCE_GAIN, 16'($urandom_range(0, 1024)));
      write_reg(CFG_TORQUE_GAIN, 16'($urandom));
      write_reg(CFG_PROP_DISTANCE, 16'($urandom_range(1, 1024)));
      stall_mode = (ph != 1);
      run_random(N_RANDOM / 5);
    end

    write_reg(CFG_SPIN_DIRECTION, 16'h0001);
    write_reg(CFG_CYCLIC_GAIN, 16'h0100);
    write_reg(CFG_PHASE_OFFSET, 16'h0000);
    write_reg(CFG_FORCE_GAIN, 16'h0100);
    write_reg(CFG_TORQUE_GAIN, 16'h0100);
    write_reg(CFG_PROP_DISTANCE, 16'h0100);
    run_random(N_RANDOM / 5);

    if (mismatches == 0)
      $display("swashplateless_rotor_mixer_core verification clean");
    else
      $display("swashplateless_rotor_mixer_core verification failed");
    $finish;
  end

endmodule
